@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks for the rtl files, used by lrutp_table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lrutp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrutp_pkg
// shared types and constants of the lru table with pinned entries
// ----------------------------------------------------------------------------
package lrutp_pkg;

   localparam int CAP_BITS = 5;
   localparam int KIND_BITS = 2;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TOUCH  = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_PROBE  = 2'd2
   } lrutp_kind_type;

   typedef struct packed {
      logic success;
      logic present;
      logic touchable;
      logic evicted;
   } lrutp_flags_type;

endpackage

@@ hw/rtl/lru_table_with_pinned_entries_unit.sv @@
// ----------------------------------------------------------------------------
// lru_table_with_pinned_entries_unit
// fully associative key table with lru replacement and pinned entries
// ----------------------------------------------------------------------------
// Each item (touch, remove or probe of a key) is captured in an input
// register, looked up against all ENTRIES slots at once and committed as it
// moves on, and its single result lands in an output register. One item is
// taken per cycle while req_stall is low; the item passes the input register
// and then the result register, around the compare-and-update of the slot
// table. A touch that misses on a full table replaces the least recent
// unpinned key, if any, and reports it; csr_wdata sets the capacity (0 acts
// as 1, values above ENTRIES act as ENTRIES). The user must write it only
// while no item is in flight; the block itself does not enforce this.
module lru_table_with_pinned_entries_unit #(
   parameter int ENTRIES = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lrutp_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [KEY_BITS-1:0]               req_key,
   input  logic                              req_pinned,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_success,
   output logic                              rsp_present,
   output logic                              rsp_touchable,
   output logic                              rsp_evicted,
   output logic [KEY_BITS-1:0]               rsp_evicted_key,
   input  logic                              csr_wen,
   input  logic [lrutp_pkg::CAP_BITS-1:0]    csr_wdata
);
   import lrutp_pkg::*;

   logic [CAP_BITS-1:0]  capacity_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [KIND_BITS-1:0] in_kind_ff;
   logic [KEY_BITS-1:0]  in_key_ff;
   logic                 in_pinned_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lrutp_flags_type      flags, flags_ff;
   logic [KEY_BITS-1:0]  evicted_key, evicted_key_ff;
   logic                 accept, out_free, advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
         end
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_kind;
         in_key_ff <= req_key;
         in_pinned_ff <= req_pinned;
      end
      if (advance) begin
         flags_ff <= flags;
         evicted_key_ff <= evicted_key;
      end
   end

   lrutp_table #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .kind        (in_kind_ff),
      .key         (in_key_ff),
      .pinned      (in_pinned_ff),
      .capacity    (capacity_ff),
      .flags       (flags),
      .evicted_key (evicted_key)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = flags_ff.success;
   assign rsp_present     = flags_ff.present;
   assign rsp_touchable   = flags_ff.touchable;
   assign rsp_evicted     = flags_ff.evicted;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

@@ hw/rtl/lrutp_table.sv @@
// ----------------------------------------------------------------------------
// lrutp_table
// key store, recency ranks and counts; evaluates and commits one item
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrutp_table #(
   parameter int ENTRIES = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic [lrutp_pkg::KIND_BITS-1:0]   kind,
   input  logic [KEY_BITS-1:0]               key,
   input  logic                              pinned,
   input  logic [lrutp_pkg::CAP_BITS-1:0]    capacity,
   output lrutp_pkg::lrutp_flags_type        flags,
   output logic [KEY_BITS-1:0]               evicted_key
);
   import lrutp_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int RW = $clog2(ENTRIES);
   localparam int AW = (CW > CAP_BITS) ? CW : CAP_BITS;

   logic [KEY_BITS-1:0] slot_key_ff [ENTRIES];
   logic [RW-1:0]       rank_ff [ENTRIES];
   logic [RW-1:0]       rank_in [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  pin_ff, pin_in;
   logic [CW-1:0]       ucount_ff, ucount_in;
   logic [CW-1:0]       pcount_ff, pcount_in;

   logic [ENTRIES-1:0]  umatch, pmatch, oldest, free_vec, first_free, ins_vec;
   logic [RW-1:0]       hit_rank;
   logic [RW-1:0]       last_rank;
   logic [KEY_BITS-1:0] victim_key;
   logic [AW-1:0]       cap_wide, cap_eff, occupancy;
   logic                hit_u, hit_p, present, touchable, full;
   logic                is_touch, is_remove, touch_hit, evict, insert, success;

   // lookup, per class
   always_comb begin
      hit_rank = '0;
      victim_key = '0;
      last_rank = RW'(ucount_ff - CW'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         umatch[i] = valid_ff[i] && !pin_ff[i] && (slot_key_ff[i] == key);
         pmatch[i] = valid_ff[i] && pin_ff[i] && (slot_key_ff[i] == key);
         // ranks are dense, so the oldest holds the highest rank in use
         oldest[i] = valid_ff[i] && !pin_ff[i] && (rank_ff[i] == last_rank);
         hit_rank = hit_rank | (rank_ff[i] & {RW{umatch[i]}});
         victim_key = victim_key | (slot_key_ff[i] & {KEY_BITS{oldest[i]}});
      end
   end

   assign free_vec = ~valid_ff;
   assign first_free = free_vec & (~free_vec + ENTRIES'(1));

   always_comb begin
      cap_wide = AW'(capacity);
      if (cap_wide == '0) begin
         cap_eff = AW'(1);
      end else if (cap_wide > AW'(ENTRIES)) begin
         cap_eff = AW'(ENTRIES);
      end else begin
         cap_eff = cap_wide;
      end
   end

   assign occupancy = AW'(ucount_ff) + AW'(pcount_ff);
   assign full      = occupancy >= cap_eff;
   assign hit_u     = |umatch;
   assign hit_p     = |pmatch;
   assign present   = hit_u || hit_p;
   assign touchable = present || (AW'(pcount_ff) < cap_eff);

   always_comb begin
      is_touch = 1'b0;
      is_remove = 1'b0;
      unique case (kind)
         KIND_TOUCH:  is_touch = 1'b1;
         KIND_REMOVE: is_remove = 1'b1;
         default:     ;
      endcase
   end

   assign touch_hit = pinned ? hit_p : hit_u;
   assign evict     = is_touch && !touch_hit && full && (ucount_ff != '0);
   assign insert    = is_touch && !touch_hit && (!full || (ucount_ff != '0));
   assign ins_vec   = evict ? oldest : first_free;

   always_comb begin
      if (is_touch) begin
         success = touch_hit || insert;
      end else begin
         success = present;
      end
   end

   assign flags.success   = success;
   assign flags.present   = present;
   assign flags.touchable = touchable;
   assign flags.evicted   = evict;
   assign evicted_key     = evict ? victim_key : '0;

   // next state
   always_comb begin
      valid_in = valid_ff;
      pin_in = pin_ff;
      ucount_in = ucount_ff;
      pcount_in = pcount_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (is_remove && hit_u) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && !pin_ff[i] && (rank_ff[i] > hit_rank)) begin
               rank_in[i] = rank_ff[i] - RW'(1);
            end
         end
         valid_in = valid_ff & ~umatch;
         ucount_in = ucount_ff - CW'(1);
      end else if (is_remove && hit_p) begin
         valid_in = valid_ff & ~pmatch;
         pin_in = pin_ff & ~pmatch;
         pcount_in = pcount_ff - CW'(1);
      end else if (is_touch && !pinned && hit_u) begin
         // promote to most recent
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && !pin_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
            if (umatch[i]) begin
               rank_in[i] = '0;
            end
         end
      end else if (insert) begin
         // the victim slot, when there is one, takes the new key
         for (int i = 0; i < ENTRIES; i++) begin
            if (!pinned && valid_ff[i] && !pin_ff[i]) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
            if (ins_vec[i]) begin
               rank_in[i] = '0;
            end
         end
         valid_in = valid_ff | ins_vec;
         pin_in = pinned ? (pin_ff | ins_vec) : (pin_ff & ~ins_vec);
         if (pinned) begin
            pcount_in = pcount_ff + CW'(1);
            ucount_in = ucount_ff - CW'(evict);
         end else begin
            ucount_in = ucount_ff + CW'(!evict);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pin_ff <= '0;
         ucount_ff <= '0;
         pcount_ff <= '0;
      end else if (update) begin
         valid_ff <= valid_in;
         pin_ff <= pin_in;
         ucount_ff <= ucount_in;
         pcount_ff <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
            if (insert && ins_vec[i]) begin
               slot_key_ff[i] <= key;
            end
         end
      end
   end

   `ASSERT_ALWAYS(a_ucount_matches, clock, reset,
      int'(ucount_ff) == $countones(valid_ff & ~pin_ff), "unpinned count out of step")
   `ASSERT_ALWAYS(a_pcount_matches, clock, reset,
      int'(pcount_ff) == $countones(valid_ff & pin_ff), "pinned count out of step")
   `ASSERT_IMPLIES(a_single_oldest, clock, reset, ucount_ff != '0, $onehot(oldest),
      "recency ranks not dense")
   `ASSERT_IMPLIES(a_evict_on_success, clock, reset, update && evict,
      success && is_touch && !touch_hit, "eviction without a placed key")

endmodule

@@ tb/sv/lru_table_with_pinned_entries_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_table_with_pinned_entries_unit_tb
// self-checking bench for the lru key table with pinned entries
// ----------------------------------------------------------------------------
// A directed opening covers the special cases: both key extremes, every kind
// including the spare code, one key held in both classes, a capacity lowered
// below occupancy, and touches refused while every stored entry is pinned.
// Random phases then run over a shared key pool at many capacity settings,
// including 0 and 31. The phases rotate through four idling patterns on both channels.
// A software copy of the table predicts every result, and the results are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module lru_table_with_pinned_entries_unit_tb;
   import lrutp_pkg::*;

   localparam int TB_ENTRIES = 16;
   localparam int KEY_BITS = 32;
   localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
   localparam int POOL_SIZE = 32;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 103;
   localparam int LONG_HOLD = 120;
   localparam int DRAIN_PAD = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      lrutp_flags_type flags;
      logic [KEY_BITS-1:0] evicted_key;
   } key_table_rsp_type;

   // software copy of the key table and the results still owed by the block
   class lru_table_scoreboard;
      logic [KEY_BITS-1:0] slot_tag [TB_ENTRIES];
      bit slot_used [TB_ENTRIES];
      bit slot_pin [TB_ENTRIES];
      int unsigned slot_age [TB_ENTRIES];
      int unsigned loose_count;
      int unsigned pin_count;
      logic [CAP_BITS-1:0] capacity;
      key_table_rsp_type awaited [$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned evictions;
      int unsigned refused_touches;

      function new();
         capacity = CAP_RESET;
         loose_count = 0;
         pin_count = 0;
         mismatches = 0;
         results_checked = 0;
         evictions = 0;
         refused_touches = 0;
         for (int i = 0; i < TB_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_pin[i] = 1'b0;
            slot_age[i] = 0;
            slot_tag[i] = '0;
         end
      endfunction

      function void set_capacity(logic [CAP_BITS-1:0] value);
         capacity = value;
      endfunction

      function int limit_now();
         if (capacity == 0) return 1;
         if (capacity > TB_ENTRIES) return TB_ENTRIES;
         return int'(capacity);
      endfunction

      function int lookup(logic [KEY_BITS-1:0] tag, bit pin);
         for (int i = 0; i < TB_ENTRIES; i++)
            if (slot_used[i] && slot_pin[i] == pin && slot_tag[i] == tag) return i;
         return -1;
      endfunction

      // ranks of the unpinned entries stay dense, 0 is the newest
      function void vacate(int s);
         int unsigned age;
         if (!slot_pin[s]) begin
            age = slot_age[s];
            for (int i = 0; i < TB_ENTRIES; i++)
               if (slot_used[i] && !slot_pin[i] && slot_age[i] > age) slot_age[i]--;
            if (loose_count > 0) loose_count--;
         end else if (pin_count > 0) begin
            pin_count--;
         end
         slot_used[s] = 1'b0;
         slot_pin[s] = 1'b0;
         slot_age[s] = 0;
      endfunction

      function void make_newest(int s);
         int unsigned age;
         age = slot_age[s];
         for (int i = 0; i < TB_ENTRIES; i++)
            if (slot_used[i] && !slot_pin[i] && slot_age[i] < age) slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      function int stalest_loose();
         int best;
         best = -1;
         for (int i = 0; i < TB_ENTRIES; i++)
            if (slot_used[i] && !slot_pin[i] && (best < 0 || slot_age[i] > slot_age[best]))
               best = i;
         return best;
      endfunction

      function void note_item(logic [KIND_BITS-1:0] kind, logic [KEY_BITS-1:0] tag, logic pin);
         key_table_rsp_type r;
         int cap;
         int loose_hit;
         int pin_hit;
         int hit;
         int victim;
         int spot;
         bit room;
         cap = limit_now();
         loose_hit = lookup(tag, 1'b0);
         pin_hit = lookup(tag, 1'b1);
         r = '0;
         r.flags.present = (loose_hit >= 0) || (pin_hit >= 0);
         r.flags.touchable = r.flags.present || (pin_count < cap);
         case (kind)
            KIND_REMOVE: begin
               // the unpinned copy goes first
               if (loose_hit >= 0) begin
                  vacate(loose_hit);
                  r.flags.success = 1'b1;
               end else if (pin_hit >= 0) begin
                  vacate(pin_hit);
                  r.flags.success = 1'b1;
               end
            end
            KIND_TOUCH: begin
               hit = pin ? pin_hit : loose_hit;
               if (hit >= 0) begin
                  if (!pin) make_newest(hit);
                  r.flags.success = 1'b1;
               end else begin
                  room = 1'b1;
                  spot = -1;
                  if (loose_count + pin_count >= cap) begin
                     victim = stalest_loose();
                     if (victim < 0) begin
                        room = 1'b0;
                     end else begin
                        r.flags.evicted = 1'b1;
                        r.evicted_key = slot_tag[victim];
                        vacate(victim);
                        evictions++;
                     end
                  end
                  if (room)
                     for (int i = 0; i < TB_ENTRIES; i++)
                        if (!slot_used[i] && spot < 0) spot = i;
                  if (spot >= 0) begin
                     if (!pin) begin
                        for (int i = 0; i < TB_ENTRIES; i++)
                           if (slot_used[i] && !slot_pin[i]) slot_age[i]++;
                        loose_count++;
                     end else begin
                        pin_count++;
                     end
                     slot_used[spot] = 1'b1;
                     slot_pin[spot] = pin;
                     slot_tag[spot] = tag;
                     slot_age[spot] = 0;
                     r.flags.success = 1'b1;
                  end else begin
                     refused_touches++;
                  end
               end
            end
            // probe, and the spare code acts as a probe
            default: r.flags.success = r.flags.present;
         endcase
         awaited.push_back(r);
      endfunction

      function void check_result(lrutp_flags_type flags, logic [KEY_BITS-1:0] ekey);
         key_table_rsp_type want;
         bit bad;
         results_checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: flags %b evicted_key %h", flags, ekey);
            return;
         end
         want = awaited.pop_front();
         bad = (flags.success !== want.flags.success) ||
               (flags.present !== want.flags.present) ||
               (flags.touchable !== want.flags.touchable) ||
               (flags.evicted !== want.flags.evicted) ||
               (ekey !== want.evicted_key);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result %0d: expected succ %b pres %b touch %b evict %b key %h",
                        results_checked, want.flags.success, want.flags.present,
                        want.flags.touchable, want.flags.evicted, want.evicted_key);
               $display("   actual succ %b pres %b touch %b evict %b key %h",
                        flags.success, flags.present, flags.touchable, flags.evicted, ekey);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [KIND_BITS-1:0] req_kind;
   logic [KEY_BITS-1:0] req_key;
   logic req_pinned;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_success;
   logic rsp_present;
   logic rsp_touchable;
   logic rsp_evicted;
   logic [KEY_BITS-1:0] rsp_evicted_key;
   logic csr_wen;
   logic [CAP_BITS-1:0] csr_wdata;

   lru_table_scoreboard book = new();
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
   bit req_gaps_on;
   bit rsp_gaps_on;
   bit long_hold_req;
   bit rsp_taken;
   int unsigned cycle_count;
   int unsigned items_sent;

   lru_table_with_pinned_entries_unit #(
      .ENTRIES(TB_ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_key(req_key),
      .req_pinned(req_pinned),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_success(rsp_success),
      .rsp_present(rsp_present),
      .rsp_touchable(rsp_touchable),
      .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, book.awaited.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // results are checked before the item of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            book.check_result({rsp_success, rsp_present, rsp_touchable, rsp_evicted},
                              rsp_evicted_key);
            rsp_taken = 1'b1;
         end
         if (req_valid && !req_stall) book.note_item(req_kind, req_key, req_pinned);
      end
   end

   // result side: a fresh stall draw after every taken result, long hold on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            stall_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (rsp_taken) begin
            stall_left = rsp_gaps_on ? $urandom_range(0, 14) : 0;
         end
         rsp_taken = 1'b0;
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   task automatic send_item(input logic [KIND_BITS-1:0] kind, input logic [KEY_BITS-1:0] tag,
                            input logic pin);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key <= tag;
      req_pinned <= pin;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
      @(negedge clock);
   endtask

   // called at a falling edge; leaves the sender idle with nothing in flight
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (book.awaited.size() != 0);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      book.set_capacity(value);
   endtask

   task automatic send_random_item();
      logic [KIND_BITS-1:0] kind;
      logic [KEY_BITS-1:0] tag;
      logic pin;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) kind = KIND_TOUCH;
      else if (sel < 72) kind = KIND_REMOVE;
      else if (sel < 95) kind = KIND_PROBE;
      else kind = KIND_SPARE;
      // mostly pooled keys so that hits and evictions happen, some pure noise
      tag = ($urandom_range(0, 19) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pin = (kind == KIND_TOUCH) ? ($urandom_range(0, 6) == 0) : 1'($urandom_range(0, 1));
      send_item(kind, tag, pin);
   endtask

   initial begin : stimulus
      int unsigned cap_plan [PHASES];
      cap_plan = '{16, 1, 31, 0, 4, 17, 8, 2, 12, 16};
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TOUCH;
      req_key = '0;
      req_pinned = 1'b0;
      rsp_stall = 1'b0;
      csr_wen = 1'b0;
      csr_wdata = CAP_RESET;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      long_hold_req = 1'b0;
      rsp_taken = 1'b0;
      cycle_count = 0;
      items_sent = 0;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < 15) ? KEY_BITS'(i) : (i == 15) ? '1 : KEY_BITS'($urandom);

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity: basic touches, one key held in both classes, all kinds
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_item(KIND_PROBE, '0, 1'b0);
      send_item(KIND_TOUCH, 32'd1, 1'b0);
      send_item(KIND_TOUCH, 32'd2, 1'b0);
      send_item(KIND_TOUCH, 32'd3, 1'b0);
      send_item(KIND_TOUCH, '0, 1'b0);
      send_item(KIND_TOUCH, '1, 1'b1);
      send_item(KIND_TOUCH, '1, 1'b0);
      send_item(KIND_TOUCH, 32'd1, 1'b0);
      send_item(KIND_TOUCH, '1, 1'b1);
      send_item(KIND_PROBE, '1, 1'b1);
      send_item(KIND_SPARE, '1, 1'b0);
      send_item(KIND_REMOVE, '1, 1'b0);
      send_item(KIND_REMOVE, '1, 1'b1);
      send_item(KIND_REMOVE, '1, 1'b0);
      settle();

      // capacity below occupancy, then pinned entries crowd out every loose one
      write_capacity(5'd2);
      send_item(KIND_TOUCH, 32'd5, 1'b0);
      send_item(KIND_TOUCH, 32'd6, 1'b0);
      send_item(KIND_TOUCH, 32'd7, 1'b1);
      send_item(KIND_TOUCH, 32'd8, 1'b1);
      send_item(KIND_TOUCH, 32'd10, 1'b1);
      send_item(KIND_TOUCH, 32'd11, 1'b1);
      send_item(KIND_TOUCH, 32'd9, 1'b0);
      send_item(KIND_TOUCH, 32'd12, 1'b1);
      send_item(KIND_PROBE, 32'd9, 1'b0);
      send_item(KIND_REMOVE, 32'd7, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_capacity(CAP_BITS'(cap_plan[p]));
         req_gaps_on = (p % 4 == 0) || (p % 4 == 1);
         rsp_gaps_on = (p % 4 == 0) || (p % 4 == 2);
         if (p == 3) begin
            // receiver holds off while the sender keeps the input full
            req_gaps_on = 1'b0;
            @(posedge clock);
            long_hold_req = 1'b1;
            @(negedge clock);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2) settle();
            send_random_item();
         end
         settle();
      end

      $display("%0d items over %0d capacity settings, %0d results checked",
               items_sent, PHASES + 2, book.results_checked);
      $display("%0d evictions and %0d refused touches seen", book.evictions,
               book.refused_touches);
      if (book.mismatches == 0 && book.awaited.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", book.mismatches,
                  book.awaited.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
